### src/modbus_frame_crc_checker_macros.svh
`ifndef MODBUS_FRAME_CRC_CHECKER_MACROS_SVH
`define MODBUS_FRAME_CRC_CHECKER_MACROS_SVH

// Same-cycle implication, sampled on i_clk and disabled while i_rst_n is low.
`define MFCC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on i_clk and disabled while i_rst_n is low.
`define MFCC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### src/mfcc_pkg.sv
`default_nettype none

package mfcc_pkg;

    localparam int BYTE_W     = 8;
    localparam int CRC_W      = 16;
    localparam int OUT_LEN_W  = 10;
    localparam int MIN_LEN_W  = 10;
    localparam int MODE_W     = 2;
    localparam int NEED_W     = 4;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 10;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;
    localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;

    localparam logic [MODE_W-1:0] MODE_RTU   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ASCII = 2'd1;
    localparam logic [MODE_W-1:0] MODE_NONE  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_MODE = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEN    = 4'd1;

    localparam logic [NEED_W-1:0] LEAD_RTU    = 4'd4;
    localparam logic [NEED_W-1:0] TRAIL_RTU   = 4'd4;
    localparam logic [NEED_W-1:0] LEAD_ASCII  = 4'd1;
    localparam logic [NEED_W-1:0] TRAIL_ASCII = 4'd2;
    localparam logic [NEED_W-1:0] LEAD_NONE   = 4'd0;
    localparam logic [NEED_W-1:0] TRAIL_NONE  = 4'd0;
    localparam logic [NEED_W-1:0] CRC_BYTES   = 4'd2;

    typedef struct packed {
        logic [BYTE_W-1:0] rx_byte;
        logic              is_last;
    } t_in_word;

    typedef struct packed {
        logic                 crc_ok;
        logic                 too_short;
        logic [CRC_W-1:0]     computed_crc;
        logic [CRC_W-1:0]     received_crc;
        logic [OUT_LEN_W-1:0] frame_len;
    } t_out_word;

    // Classified byte handed from the front to the back through the queue.
    typedef struct packed {
        logic [BYTE_W-1:0]    rx_byte;
        logic                 is_last;
        logic                 in_body;
        logic                 len_short;
        logic [NEED_W-1:0]    need;
        logic [OUT_LEN_W-1:0] frame_len;
    } t_cls_word;

    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
        for (int i = 0; i < BYTE_W; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

### src/mfcc_front.sv
`default_nettype none

module mfcc_front #(
    parameter int LEN_BITS   = 10,
    parameter int HOLD_DEPTH = 6
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_in_valid,
    output logic                            o_in_ready,
    input  mfcc_pkg::t_in_word              i_in_word,
    input  wire                             i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire [mfcc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire [mfcc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire                             i_q_ready,
    output logic                            o_q_push,
    output mfcc_pkg::t_cls_word             o_q_word
);
    import mfcc_pkg::*;

    localparam int CMP_W = (LEN_BITS > MIN_LEN_W) ? LEN_BITS : MIN_LEN_W;
    localparam logic [LEN_BITS-1:0] LEN_MAX = {LEN_BITS{1'b1}};

    logic [MODE_W-1:0]    r_frame_mode;
    logic [MIN_LEN_W-1:0] r_min_len;
    logic [LEN_BITS-1:0]  r_byte_count;
    logic [LEN_BITS-1:0]  n_byte_count;

    logic [NEED_W-1:0]    lead;
    logic [NEED_W-1:0]    trail;
    logic [NEED_W-1:0]    need_full;
    logic [LEN_BITS-1:0]  cnt_inc;

    always_comb begin
        unique case (r_frame_mode)
            MODE_RTU: begin
                lead  = LEAD_RTU;
                trail = TRAIL_RTU;
            end
            MODE_ASCII: begin
                lead  = LEAD_ASCII;
                trail = TRAIL_ASCII;
            end
            // The unused code behaves as mode none.
            default: begin
                lead  = LEAD_NONE;
                trail = TRAIL_NONE;
            end
        endcase
    end

    assign need_full = trail + CRC_BYTES;
    assign cnt_inc   = (r_byte_count == LEN_MAX) ? r_byte_count : r_byte_count + 1'b1;

    assign o_in_ready  = i_q_ready;
    assign o_q_push    = i_in_valid && i_q_ready;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        o_q_word.rx_byte   = i_in_word.rx_byte;
        o_q_word.is_last   = i_in_word.is_last;
        o_q_word.in_body   = CMP_W'(r_byte_count) >= CMP_W'(lead);
        o_q_word.len_short = CMP_W'(cnt_inc) <= CMP_W'(r_min_len);
        o_q_word.need      = (CMP_W'(need_full) > CMP_W'(HOLD_DEPTH))
                             ? NEED_W'(HOLD_DEPTH) : need_full;
        o_q_word.frame_len = OUT_LEN_W'(cnt_inc);
    end

    always_comb begin
        n_byte_count = r_byte_count;
        if (o_q_push) begin
            n_byte_count = i_in_word.is_last ? '0 : cnt_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_mode <= MODE_RTU;
            r_min_len    <= '0;
            r_byte_count <= '0;
        end else begin
            r_byte_count <= n_byte_count;
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_FRAME_MODE) begin
                    r_frame_mode <= i_cfg_data[MODE_W-1:0];
                end else if (i_cfg_index == CFG_MIN_LEN) begin
                    r_min_len <= i_cfg_data[MIN_LEN_W-1:0];
                end
            end
        end
    end

endmodule

`default_nettype wire

### src/mfcc_fifo.sv
`default_nettype none

module mfcc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  wire [WIDTH-1:0]  i_data,
    output logic             o_ready,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data,
    input  wire              i_pop
);
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;
    logic             do_push;
    logic             do_pop;

    assign o_ready = r_count != CNT_W'(DEPTH);
    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

`default_nettype wire

### src/mfcc_back.sv
`default_nettype none

module mfcc_back #(
    parameter int HOLD_DEPTH = 6
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_head_valid,
    input  mfcc_pkg::t_cls_word  i_head,
    output logic                 o_pop,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output mfcc_pkg::t_out_word  o_out_word
);
    import mfcc_pkg::*;

    localparam int FILL_W = $clog2(HOLD_DEPTH + 1);
    localparam int CW     = (FILL_W > NEED_W) ? FILL_W : NEED_W;

    logic [BYTE_W-1:0] r_line [HOLD_DEPTH];
    logic [FILL_W-1:0] r_fill;
    logic [CRC_W-1:0]  r_crc;
    logic              r_out_valid;
    t_out_word         r_out_word;

    logic [BYTE_W-1:0] n_line [HOLD_DEPTH];
    logic [FILL_W-1:0] n_fill;
    logic [CRC_W-1:0]  n_crc;

    logic [BYTE_W-1:0] line_p [HOLD_DEPTH];
    logic [FILL_W-1:0] fill_p;
    logic [CW-1:0]     need_c;
    logic [CW-1:0]     fill_c;
    logic              out_room;
    logic              surplus;
    logic              advance;
    logic              pop_byte;
    logic              push_byte;
    logic              finish;
    logic              short_frame;
    logic [CRC_W-1:0]  rec_crc;

    assign need_c   = CW'(i_head.need);
    assign fill_c   = CW'(r_fill);
    assign out_room = !r_out_valid || i_out_ready;

    // A held count larger than the current need (after a mode change) drains
    // one oldest byte per cycle before the head byte is taken.
    assign surplus   = i_head.in_body && (fill_c > need_c);
    assign advance   = i_head_valid && (surplus || !i_head.is_last || out_room);
    assign pop_byte  = advance && i_head.in_body && (fill_c >= need_c) && (r_fill != '0);
    assign push_byte = advance && i_head.in_body && !surplus;
    assign o_pop     = advance && !surplus;
    assign finish    = o_pop && i_head.is_last;

    always_comb begin
        for (int i = 0; i < HOLD_DEPTH - 1; i++) begin
            line_p[i] = pop_byte ? r_line[i + 1] : r_line[i];
        end
        line_p[HOLD_DEPTH - 1] = pop_byte ? '0 : r_line[HOLD_DEPTH - 1];
        fill_p = pop_byte ? r_fill - 1'b1 : r_fill;
        n_crc  = pop_byte ? crc_byte(r_crc, r_line[0]) : r_crc;

        for (int i = 0; i < HOLD_DEPTH; i++) begin
            n_line[i] = (push_byte && fill_p == FILL_W'(i)) ? i_head.rx_byte : line_p[i];
        end
        n_fill = push_byte ? fill_p + 1'b1 : fill_p;

        rec_crc     = (n_fill >= FILL_W'(2)) ? {n_line[0], n_line[1]} : '0;
        short_frame = i_head.len_short || (CW'(n_fill) < need_c);
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    always_ff @(posedge i_clk) begin
        r_line <= n_line;
        if (finish) begin
            r_out_word.crc_ok       <= !short_frame && (rec_crc == n_crc);
            r_out_word.too_short    <= short_frame;
            r_out_word.computed_crc <= n_crc;
            r_out_word.received_crc <= rec_crc;
            r_out_word.frame_len    <= i_head.frame_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_crc       <= CRC_INIT;
            r_out_valid <= 1'b0;
        end else begin
            if (finish) begin
                r_fill      <= '0;
                r_crc       <= CRC_INIT;
                r_out_valid <= 1'b1;
            end else begin
                r_fill <= n_fill;
                r_crc  <= n_crc;
                if (i_out_ready) begin
                    r_out_valid <= 1'b0;
                end
            end
        end
    end

endmodule

`default_nettype wire

### src/modbus_frame_crc_checker.sv
// A last byte, with the queue empty ahead of it, is registered in the queue, then in the result
// word; it stalls while surplus held bytes from a mode change drain or a result word is held.
// Throughput: one byte per cycle bar those stalls, set by the back end's single byte-wide CRC.
// Reset: synchronous, active low; clears the mode, the minimum length, the queue,
// the byte counter, the held count and the CRC, and drops the output word.
`default_nettype none
`include "modbus_frame_crc_checker_macros.svh"

module modbus_frame_crc_checker #(
    parameter int LEN_BITS   = 10,
    parameter int HOLD_DEPTH = 6
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_in_valid,
    output logic                            o_in_ready,
    input  mfcc_pkg::t_in_word              i_in_word,
    output logic                            o_out_valid,
    input  wire                             i_out_ready,
    output mfcc_pkg::t_out_word             o_out_word,
    input  wire                             i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire [mfcc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire [mfcc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import mfcc_pkg::*;

    localparam int CLS_W = $bits(t_cls_word);

    logic             w_q_ready;
    logic             w_q_push;
    t_cls_word        w_q_word;
    logic             w_q_valid;
    logic [CLS_W-1:0] w_head_bits;
    t_cls_word        w_head;
    logic             w_q_pop;
    logic             w_head_last;
    logic             w_out_ok;
    logic             w_crc_match;

    mfcc_front #(
        .LEN_BITS   (LEN_BITS),
        .HOLD_DEPTH (HOLD_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_ready   (w_q_ready),
        .o_q_push    (w_q_push),
        .o_q_word    (w_q_word)
    );

    mfcc_fifo #(
        .WIDTH (CLS_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_q_word),
        .o_ready (w_q_ready),
        .o_valid (w_q_valid),
        .o_data  (w_head_bits),
        .i_pop   (w_q_pop)
    );

    assign w_head = t_cls_word'(w_head_bits);

    mfcc_back #(
        .HOLD_DEPTH (HOLD_DEPTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (w_q_valid),
        .i_head       (w_head),
        .o_pop        (w_q_pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_word   (o_out_word)
    );

    assign w_head_last = w_q_pop && w_head.is_last;
    assign w_out_ok    = o_out_valid && o_out_word.crc_ok;
    assign w_crc_match = !o_out_word.too_short
                         && (o_out_word.computed_crc == o_out_word.received_crc);

    `MFCC_ASSERT_IMP(a_pop_needs_word, w_q_pop, w_q_valid, "pop from an empty queue")
    `MFCC_ASSERT_IMP(a_ok_is_match, w_out_ok, w_crc_match, "crc_ok on a bad frame")
    `MFCC_ASSERT_NXT(a_last_gives_result, w_head_last, o_out_valid, "no result for a last byte")
    `MFCC_ASSERT_IMP(a_result_from_last, $rose(o_out_valid), $past(w_head_last), "stray result")

endmodule

`default_nettype wire

### bench/modbus_frame_crc_checker_chk.sv
`timescale 1ns / 1ps

package mfcc_tb_crc_pkg;

    import mfcc_pkg::*;

    // One byte folded into a reflected CRC-16, least significant bit first.
    function automatic logic [CRC_W-1:0] crc16_fold(input logic [CRC_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] data);
        logic [CRC_W-1:0] acc;
        acc = crc ^ {{(CRC_W-BYTE_W){1'b0}}, data};
        for (int k = 0; k < BYTE_W; k++) begin
            if (acc[0]) begin
                acc = (acc >> 1) ^ CRC_POLY;
            end else begin
                acc = acc >> 1;
            end
        end
        return acc;
    endfunction

endpackage

module mfcc_verdict_checker
    import mfcc_pkg::*;
    import mfcc_tb_crc_pkg::*;
#(
    parameter int LEN_BITS   = 10,
    parameter int HOLD_DEPTH = 6
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    input  wire                   i_in_ready,
    input  t_in_word              i_in_word,
    input  wire                   i_out_valid,
    input  wire                   i_out_ready,
    input  t_out_word             i_out_word,
    input  wire                   i_cfg_valid,
    input  wire                   i_cfg_ready,
    input  wire [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire [CFG_DATA_W-1:0]  i_cfg_data,
    output int                    o_fail_count,
    output int                    o_expect_cnt
);

    localparam int unsigned LEN_MAX = (1 << LEN_BITS) - 1;

    logic [MODE_W-1:0]    mode_q;
    logic [MIN_LEN_W-1:0] min_len_q;

    logic [CRC_W-1:0]     body_crc;
    int unsigned          byte_cnt;
    logic [BYTE_W-1:0]    held [HOLD_DEPTH];
    int unsigned          held_cnt;

    t_out_word            verdicts_q [$];
    int                   fail_total = 0;

    function automatic void clear_frame();
        body_crc = CRC_INIT;
        byte_cnt = 0;
        held_cnt = 0;
        for (int k = 0; k < HOLD_DEPTH; k++) begin
            held[k] = '0;
        end
    endfunction

    // Advances the frame state by one accepted byte; returns 1 with the verdict on the
    // final byte of a frame.
    function automatic bit absorb_frame_byte(input t_in_word w, output t_out_word verdict);
        int unsigned      lead;
        int unsigned      trail;
        int unsigned      need_cnt;
        int unsigned      pos;
        logic [CRC_W-1:0] rec;
        logic             short_f;
        verdict = '0;
        case (mode_q)
            MODE_RTU: begin
                lead  = LEAD_RTU;
                trail = TRAIL_RTU;
            end
            MODE_ASCII: begin
                lead  = LEAD_ASCII;
                trail = TRAIL_ASCII;
            end
            default: begin
                lead  = LEAD_NONE;
                trail = TRAIL_NONE;
            end
        endcase
        need_cnt = trail + CRC_BYTES;
        if (need_cnt > HOLD_DEPTH) begin
            need_cnt = HOLD_DEPTH;
        end
        pos = byte_cnt;
        if (byte_cnt < LEN_MAX) begin
            byte_cnt++;
        end
        if (pos >= lead) begin
            // A shrunken need count after a mode change drains several held bytes into the CRC at once.
            while (held_cnt >= need_cnt && held_cnt > 0) begin
                body_crc = crc16_fold(body_crc, held[0]);
                for (int k = 0; k < HOLD_DEPTH - 1; k++) begin
                    held[k] = held[k+1];
                end
                held[HOLD_DEPTH-1] = '0;
                held_cnt--;
            end
            if (held_cnt < HOLD_DEPTH) begin
                held[held_cnt] = w.rx_byte;
                held_cnt++;
            end
        end
        if (!w.is_last) begin
            return 1'b0;
        end
        rec = (held_cnt >= CRC_BYTES) ? {held[0], held[1]} : '0;
        short_f = (byte_cnt <= min_len_q) || (held_cnt < need_cnt);
        verdict.crc_ok       = !short_f && (rec == body_crc);
        verdict.too_short    = short_f;
        verdict.computed_crc = body_crc;
        verdict.received_crc = rec;
        verdict.frame_len    = OUT_LEN_W'(byte_cnt);
        clear_frame();
        return 1'b1;
    endfunction

    function automatic void check_field(input string what, input logic [CRC_W-1:0] want,
                                        input logic [CRC_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
            fail_total++;
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_out_word want;
        t_out_word predicted;
        if (!i_rst_n) begin
            mode_q    = MODE_RTU;
            min_len_q = '0;
            clear_frame();
            verdicts_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_FRAME_MODE) begin
                    mode_q = i_cfg_data[MODE_W-1:0];
                end else if (i_cfg_index == CFG_MIN_LEN) begin
                    min_len_q = i_cfg_data[MIN_LEN_W-1:0];
                end
            end
            if (i_out_valid && i_out_ready) begin
                if (verdicts_q.size() == 0) begin
                    $display("%0t: result word with no frame pending, expected none, got %p",
                             $time, i_out_word);
                    fail_total++;
                end else begin
                    want = verdicts_q.pop_front();
                    check_field("crc_ok", want.crc_ok, i_out_word.crc_ok);
                    check_field("too_short", want.too_short, i_out_word.too_short);
                    check_field("computed_crc", want.computed_crc, i_out_word.computed_crc);
                    check_field("received_crc", want.received_crc, i_out_word.received_crc);
                    check_field("frame_len", want.frame_len, i_out_word.frame_len);
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (absorb_frame_byte(i_in_word, predicted)) begin
                    verdicts_q = {verdicts_q, predicted};
                end
            end
        end
        o_expect_cnt <= verdicts_q.size();
        o_fail_count <= fail_total;
    end

endmodule

### bench/modbus_frame_crc_checker_tb.sv
`timescale 1ns / 1ps

module modbus_frame_crc_checker_tb;

    import mfcc_pkg::*;
    import mfcc_tb_crc_pkg::*;

    localparam int                   CYCLE_LIMIT      = 600000;
    localparam int                   SETTLE_CYCLES    = 20;
    localparam int                   LONG_HOLD_CYCLES = 400;
    localparam int                   PHASE_BYTES      = 110;
    localparam int                   FRAME_MAX        = 1040;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX   = 4'hF;
    localparam logic [MODE_W-1:0]    MODE_SPARE       = 2'd3;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    t_in_word              in_word = '0;
    logic                  out_ready = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    wire                   o_in_ready;
    wire                   o_out_valid;
    t_out_word             o_out_word;
    wire                   o_cfg_ready;
    int                    fail_count;
    int                    expect_cnt;

    int                    send_idle_pct = 0;
    int                    recv_stall_pct = 0;
    logic                  hold_trigger = 1'b0;
    logic                  hold_taken = 1'b0;
    int                    hold_left = 0;
    int                    cycles_run = 0;
    int                    bytes_sent = 0;
    logic [MODE_W-1:0]     cur_mode = MODE_RTU;

    always #5 i_clk = ~i_clk;

    modbus_frame_crc_checker u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (o_out_word),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    mfcc_verdict_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_word    (in_word),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (out_ready),
        .i_out_word   (o_out_word),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_expect_cnt (expect_cnt)
    );

    // Result side: random stalls, plus one long hold-off once the stimulus asks for it.
    always @(posedge i_clk) begin
        if (hold_trigger && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_left  <= LONG_HOLD_CYCLES;
            out_ready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycles_run <= cycles_run + 1;
        if (cycles_run >= CYCLE_LIMIT) begin
            $display("modbus_frame_crc_checker_tb NOT OK");
            $finish;
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] value, input logic last);
        t_in_word w;
        w.rx_byte = value;
        w.is_last = last;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge i_clk); while (!o_in_ready);
        bytes_sent++;
    endtask

    // Builds a frame for the current mode with a matching CRC; a spoiled frame gets
    // one bit flipped somewhere.
    task automatic send_frame(input int body_len, input bit spoil);
        logic [BYTE_W-1:0] bytes_a [FRAME_MAX];
        logic [BYTE_W-1:0] b;
        logic [CRC_W-1:0]  crc;
        int                byte_total;
        int                lead;
        int                trail;
        int                pick;
        crc = CRC_INIT;
        byte_total = 0;
        case (cur_mode)
            MODE_RTU: begin
                lead  = LEAD_RTU;
                trail = TRAIL_RTU;
            end
            MODE_ASCII: begin
                lead  = LEAD_ASCII;
                trail = TRAIL_ASCII;
            end
            default: begin
                lead  = LEAD_NONE;
                trail = TRAIL_NONE;
            end
        endcase
        repeat (lead) begin
            bytes_a[byte_total] = BYTE_W'($urandom_range(0, 255));
            byte_total++;
        end
        repeat (body_len) begin
            b = BYTE_W'($urandom_range(0, 255));
            crc = crc16_fold(crc, b);
            bytes_a[byte_total] = b;
            byte_total++;
        end
        bytes_a[byte_total]     = crc[15:8];
        bytes_a[byte_total + 1] = crc[7:0];
        byte_total += 2;
        repeat (trail) begin
            bytes_a[byte_total] = BYTE_W'($urandom_range(0, 255));
            byte_total++;
        end
        if (spoil) begin
            pick = $urandom_range(0, byte_total - 1);
            bytes_a[pick] = bytes_a[pick] ^ BYTE_W'(1 << $urandom_range(0, 7));
        end
        for (int i = 0; i < byte_total; i++) begin
            send_byte(bytes_a[i], i == byte_total - 1);
        end
    endtask

    task automatic send_noise(input int len, input bit close_frame);
        for (int i = 0; i < len; i++) begin
            send_byte(BYTE_W'($urandom_range(0, 255)), close_frame && (i == len - 1));
        end
    endtask

    // Drops valid and waits until every expected word has come back and the
    // block has had time to finish any held-byte draining.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (expect_cnt != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data, input bit keep_valid);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (!keep_valid) begin
            cfg_valid <= 1'b0;
        end
        if (idx == CFG_FRAME_MODE) begin
            cur_mode = data[MODE_W-1:0];
        end
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] mode_data,
                             input logic [MIN_LEN_W-1:0] min_len);
        write_cfg(CFG_FRAME_MODE, mode_data, 1'b1);
        write_cfg(CFG_MIN_LEN, min_len, 1'b0);
    endtask

    initial begin
        int phase_start;
        int pick;
        logic [MODE_W-1:0]    mode_sel;
        logic [MIN_LEN_W-1:0] min_sel;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset settings are rtu with no minimum; last flag on a lead-in byte.
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        settle();
        write_cfg(CFG_UNUSED_IDX, CFG_DATA_W'($urandom_range(0, 1023)), 1'b0);
        configure(CFG_DATA_W'(MODE_NONE), '0);
        // Empty body: the received 0xFFFF matches the initial CRC.
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h80, 1'b1);
        settle();
        // All data bits set selects the unused mode, which behaves as no framing.
        configure({{(CFG_DATA_W-MODE_W){1'b1}}, MODE_SPARE}, '0);
        send_frame(1, 1'b0);
        settle();
        configure(CFG_DATA_W'(MODE_ASCII), MIN_LEN_W'(3));
        send_frame(1, 1'b0);
        settle();
        // Mode change in the middle of a frame.
        configure(CFG_DATA_W'(MODE_RTU), '0);
        send_noise(6, 1'b0);
        settle();
        configure(CFG_DATA_W'(MODE_NONE), '0);
        send_noise(2, 1'b1);
        settle();

        // Long hold-off on the result side while short frames keep coming.
        hold_trigger <= 1'b1;
        repeat (40) send_frame($urandom_range(0, 1), 1'b0);
        settle();

        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
                default: begin send_idle_pct = 32; recv_stall_pct = 32; end
            endcase
            mode_sel = MODE_W'(ph / 2);
            if (ph == 0) begin
                min_sel = '0;
            end else if (ph == 7) begin
                min_sel = '1;
            end else if (ph == 3) begin
                min_sel = MIN_LEN_W'($urandom_range(0, 1023));
            end else begin
                min_sel = MIN_LEN_W'($urandom_range(0, 14));
            end
            configure(CFG_DATA_W'(($urandom_range(0, 255) << MODE_W) | mode_sel), min_sel);
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES) begin
                pick = $urandom_range(0, 99);
                if (pick < 70) begin
                    send_frame($urandom_range(0, 10), 1'b0);
                end else if (pick < 85) begin
                    send_frame($urandom_range(0, 10), 1'b1);
                end else begin
                    send_noise($urandom_range(1, 12), 1'b1);
                end
            end
            // Leave a frame open so the next setting lands mid-frame.
            if (ph % 2 == 1) begin
                send_noise($urandom_range(1, 8), 1'b0);
            end
            settle();
        end

        // One frame past the length counter's saturation point.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        configure(CFG_DATA_W'(MODE_NONE), MIN_LEN_W'(1022));
        send_frame(1030, 1'b0);
        settle();

        if (fail_count == 0) begin
            $display("modbus_frame_crc_checker_tb OK");
        end else begin
            $display("modbus_frame_crc_checker_tb NOT OK");
        end
        $finish;
    end

endmodule
